FILE: hw/rtl/nsss_pkg.sv
// Shared types, constants and sequence tables for the SSS sequence generator.
`default_nettype none

package nsss_pkg;

    localparam int SEQ_LEN        = 127;
    localparam int SEED_LEN       = 7;
    localparam int CHIPS_PER_WORD = 8;
    localparam int WORD_COUNT     = (SEQ_LEN + CHIPS_PER_WORD - 1) / CHIPS_PER_WORD;
    localparam int LAST_CHIPS     = SEQ_LEN - (WORD_COUNT - 1) * CHIPS_PER_WORD;

    localparam int GROUP_W    = 9;
    localparam int SECTOR_W   = 2;
    localparam int WORD_W     = 8;
    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 4;
    localparam int M0_W       = 6;
    localparam int M1_W       = 7;

    localparam int GROUP_MAX  = 335;
    localparam int SECTOR_MAX = 2;
    localparam int GROUP_SPAN = 112;
    localparam int M0_GROUP_STEP  = 15;
    localparam int M0_SECTOR_STEP = 5;
    localparam int TAP_X0     = 4;
    localparam int TAP_X1     = 1;

    function automatic logic [SEQ_LEN-1:0] build_mseq(input int tap);
        logic [SEQ_LEN-1:0] x;
        int i;
        x    = '0;
        x[0] = 1'b1;
        for (i = 0; i < SEQ_LEN - SEED_LEN; i++)
        begin
            x[i + SEED_LEN] = x[i + tap] ^ x[i];
        end
        return x;
    endfunction

    localparam logic [SEQ_LEN-1:0] X0_SEQ = build_mseq(TAP_X0);
    localparam logic [SEQ_LEN-1:0] X1_SEQ = build_mseq(TAP_X1);

    typedef struct packed {
        logic [M0_W-1:0] m0;
        logic [M1_W-1:0] m1;
        logic            invalid;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nsss_front.sv
// Request front end: range check and cyclic shift computation.
`default_nettype none

module nsss_front (
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [nsss_pkg::GROUP_W-1:0]  cell_group,
    input  wire logic [nsss_pkg::SECTOR_W-1:0] cell_sector,
    input  wire logic                          q_full,
    output logic                               q_push,
    output nsss_pkg::cmd_t                     q_cmd
);

    logic [1:0]                     quot;
    logic [nsss_pkg::GROUP_W-1:0]   rem;

    always_comb
    begin
        if (cell_group >= nsss_pkg::GROUP_W'(2 * nsss_pkg::GROUP_SPAN))
        begin
            quot = 2'd2;
        end
        else if (cell_group >= nsss_pkg::GROUP_W'(nsss_pkg::GROUP_SPAN))
        begin
            quot = 2'd1;
        end
        else
        begin
            quot = 2'd0;
        end
        rem = cell_group - nsss_pkg::GROUP_W'(nsss_pkg::GROUP_SPAN * quot);
    end

    always_comb
    begin
        q_cmd.m0 = nsss_pkg::M0_W'(nsss_pkg::M0_GROUP_STEP * quot)
                 + nsss_pkg::M0_W'(nsss_pkg::M0_SECTOR_STEP * cell_sector);
        q_cmd.m1 = rem[nsss_pkg::M1_W-1:0];
        q_cmd.invalid = (cell_group > nsss_pkg::GROUP_W'(nsss_pkg::GROUP_MAX))
                     || (cell_sector > nsss_pkg::SECTOR_W'(nsss_pkg::SECTOR_MAX));
    end

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

FILE: hw/rtl/nsss_queue.sv
// Two-entry command queue between front end and sequence engine.
`default_nettype none

module nsss_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire nsss_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output nsss_pkg::cmd_t      head_cmd
);

    nsss_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: hw/rtl/nsss_back.sv
// Sequence engine: rotates both m-sequences and streams chip words.
`default_nettype none

module nsss_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            head_valid,
    input  wire nsss_pkg::cmd_t                  head_cmd,
    output logic                                 pop,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [nsss_pkg::WORD_W-1:0]          chip_word,
    output logic [nsss_pkg::IDX_W-1:0]           word_index,
    output logic [nsss_pkg::COUNT_W-1:0]         chip_count,
    output logic                                 id_invalid,
    output logic                                 last_word
);

    logic         busy_reg, busy_next;
    logic [nsss_pkg::SEQ_LEN-1:0] rot0_reg, rot0_next;
    logic [nsss_pkg::SEQ_LEN-1:0] rot1_reg, rot1_next;
    logic [nsss_pkg::IDX_W-1:0] widx_reg, widx_next;

    logic         out_valid_reg, out_valid_next;
    logic [nsss_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [nsss_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [nsss_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic         inv_reg, inv_next;
    logic         last_reg, last_next;

    logic         adv;
    logic         src_ok;
    logic [nsss_pkg::SEQ_LEN-1:0] cur0, cur1, chips;
    logic [2*nsss_pkg::SEQ_LEN-1:0] wide0, wide1;
    logic [nsss_pkg::IDX_W-1:0] cur_idx;
    logic         is_last;

    always_comb
    begin
        wide0 = {nsss_pkg::X0_SEQ, nsss_pkg::X0_SEQ} >> head_cmd.m0;
        wide1 = {nsss_pkg::X1_SEQ, nsss_pkg::X1_SEQ} >> head_cmd.m1;
        cur0    = busy_reg ? rot0_reg : wide0[nsss_pkg::SEQ_LEN-1:0];
        cur1    = busy_reg ? rot1_reg : wide1[nsss_pkg::SEQ_LEN-1:0];
        cur_idx = busy_reg ? widx_reg : '0;
        chips   = cur0 ^ cur1;
        is_last = cur_idx == nsss_pkg::IDX_W'(nsss_pkg::WORD_COUNT - 1);

        adv    = !out_valid_reg || rsp_ready;
        src_ok = busy_reg || head_valid;
        pop    = adv && !busy_reg && head_valid;

        busy_next      = busy_reg;
        rot0_next      = rot0_reg;
        rot1_next      = rot1_reg;
        widx_next      = widx_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        word_next      = word_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        inv_next       = inv_reg;
        last_next      = last_reg;

        if (adv && src_ok)
        begin
            out_valid_next = 1'b1;
            if (!busy_reg && head_cmd.invalid)
            begin
                word_next = '0;
                idx_next  = '0;
                cnt_next  = '0;
                inv_next  = 1'b1;
                last_next = 1'b1;
            end
            else
            begin
                word_next = chips[nsss_pkg::WORD_W-1:0];
                idx_next  = cur_idx;
                cnt_next  = is_last ? nsss_pkg::COUNT_W'(nsss_pkg::LAST_CHIPS)
                                    : nsss_pkg::COUNT_W'(nsss_pkg::CHIPS_PER_WORD);
                inv_next  = 1'b0;
                last_next = is_last;
                busy_next = !is_last;
                rot0_next = cur0 >> nsss_pkg::CHIPS_PER_WORD;
                rot1_next = cur1 >> nsss_pkg::CHIPS_PER_WORD;
                widx_next = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rot0_reg <= rot0_next;
        rot1_reg <= rot1_next;
        widx_reg <= widx_next;
        word_reg <= word_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        inv_reg  <= inv_next;
        last_reg <= last_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign chip_word  = word_reg;
    assign word_index = idx_reg;
    assign chip_count = cnt_reg;
    assign id_invalid = inv_reg;
    assign last_word  = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nr_sss_sequence_generator.sv
// Top level of the NR secondary synchronization sequence generator.
//
// Request channel (req_valid/req_ready) takes one word: cell_group and
// cell_sector. Response channel (rsp_valid/rsp_ready) returns the 127-chip
// sequence as 16 words of 8 chips, word_index 0..15, the last word holding
// 7 chips and marked by last_word. An identity out of range (group above
// 335 or sector 3) yields a single word with id_invalid and last_word set.
// A taken request is stored in the command queue, and each word is registered in
// the single output word register of the sequence engine. Words stream one per
// cycle while the receiver is ready; a flagged request yields one word.
// A two-entry command queue lets up to two requests wait
// while the engine streams, so requests are taken during output.
// Reset clears the queue and the engine; no clearing pass is needed.
// When the receiver stalls, the current word holds and the engine waits;
// the request side stays ready until the queue fills.
`default_nettype none

module nr_sss_sequence_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire logic [nsss_pkg::GROUP_W-1:0]        cell_group,
    input  wire logic [nsss_pkg::SECTOR_W-1:0]       cell_sector,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output logic [nsss_pkg::WORD_W-1:0]              chip_word,
    output logic [nsss_pkg::IDX_W-1:0]               word_index,
    output logic [nsss_pkg::COUNT_W-1:0]             chip_count,
    output logic                                     id_invalid,
    output logic                                     last_word
);

    logic           q_full;
    logic           q_push;
    nsss_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           head_valid;
    nsss_pkg::cmd_t head_cmd;

    nsss_front u_front (
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cell_group  (cell_group),
        .cell_sector (cell_sector),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    nsss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    nsss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .chip_word  (chip_word),
        .word_index (word_index),
        .chip_count (chip_count),
        .id_invalid (id_invalid),
        .last_word  (last_word)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/nsss_checker.sv
// Port-level assertions for the SSS sequence generator, bound to the top level.
`default_nettype none

module nsss_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [nsss_pkg::WORD_W-1:0]   chip_word,
    input  wire logic [nsss_pkg::IDX_W-1:0]    word_index,
    input  wire logic [nsss_pkg::COUNT_W-1:0]  chip_count,
    input  wire logic                          id_invalid,
    input  wire logic                          last_word
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(chip_word)
            && $stable(word_index) && $stable(last_word))
        else $error("response word changed while stalled");

    a_flagged_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && id_invalid |-> last_word && chip_count == '0
            && word_index == '0 && chip_word == '0)
        else $error("flagged word malformed");

    a_word_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !last_word |=> rsp_valid
            && word_index == nsss_pkg::IDX_W'($past(word_index) + 1'b1))
        else $error("sequence word stream broken");

    a_last_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && last_word && !id_invalid |->
            word_index == nsss_pkg::IDX_W'(nsss_pkg::WORD_COUNT - 1)
            && chip_count == nsss_pkg::COUNT_W'(nsss_pkg::LAST_CHIPS)
            && !chip_word[nsss_pkg::WORD_W-1])
        else $error("last word malformed");

endmodule

bind nr_sss_sequence_generator nsss_checker u_nsss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .chip_word  (chip_word),
    .word_index (word_index),
    .chip_count (chip_count),
    .id_invalid (id_invalid),
    .last_word  (last_word)
);

`default_nettype wire

FILE: test/tb_nr_sss_sequence_generator.sv
// Self-checking testbench for the NR SSS chip sequence generator.
module tb_nr_sss_sequence_generator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [nsss_pkg::GROUP_W-1:0]  group;
        logic [nsss_pkg::SECTOR_W-1:0] sector;
    } cell_id_t;

    typedef struct {
        logic [nsss_pkg::WORD_W-1:0]  chips;
        logic [nsss_pkg::IDX_W-1:0]   index;
        logic [nsss_pkg::COUNT_W-1:0] count;
        logic                         invalid;
        logic                         last;
    } sss_word_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          req_valid   = 1'b0;
    logic                          req_ready;
    logic [nsss_pkg::GROUP_W-1:0]  cell_group  = '0;
    logic [nsss_pkg::SECTOR_W-1:0] cell_sector = '0;
    logic                          rsp_valid;
    logic                          rsp_ready   = 1'b0;
    logic [nsss_pkg::WORD_W-1:0]   chip_word;
    logic [nsss_pkg::IDX_W-1:0]    word_index;
    logic [nsss_pkg::COUNT_W-1:0]  chip_count;
    logic                          id_invalid;
    logic                          last_word;

    cell_id_t  id_queue[$];
    sss_word_t expected_words[$];
    int        mismatches = 0;
    int        req_gap    = 0;
    bit        req_burst  = 1'b0;
    int        rsp_gap    = 0;
    bit        rsp_burst  = 1'b0;

    nr_sss_sequence_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cell_group  (cell_group),
        .cell_sector (cell_sector),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .chip_word   (chip_word),
        .word_index  (word_index),
        .chip_count  (chip_count),
        .id_invalid  (id_invalid),
        .last_word   (last_word)
    );

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic bit [nsss_pkg::SEQ_LEN-1:0] sss_chips(input int unsigned grp,
                                                             input int unsigned sec);
        bit [nsss_pkg::SEQ_LEN-1:0] xa;
        bit [nsss_pkg::SEQ_LEN-1:0] xb;
        bit [nsss_pkg::SEQ_LEN-1:0] seq;
        int unsigned                m0;
        int unsigned                m1;
        int                         i;
        xa    = '0;
        xb    = '0;
        xa[0] = 1'b1;
        xb[0] = 1'b1;
        for (i = 0; i < nsss_pkg::SEQ_LEN - 7; i++)
        begin
            xa[i + 7] = xa[i + 4] ^ xa[i];
            xb[i + 7] = xb[i + 1] ^ xb[i];
        end
        m0 = 15 * (grp / 112) + 5 * sec;
        m1 = grp % 112;
        for (i = 0; i < nsss_pkg::SEQ_LEN; i++)
        begin
            seq[i] = xa[(i + m0) % nsss_pkg::SEQ_LEN] ^ xb[(i + m1) % nsss_pkg::SEQ_LEN];
        end
        return seq;
    endfunction

    task automatic predict_sss_words(input cell_id_t id);
        bit [nsss_pkg::SEQ_LEN-1:0] seq;
        sss_word_t                  w;
        int                         n_words;
        int                         wi;
        int                         k;
        int                         n;
        if (id.group > nsss_pkg::GROUP_MAX || id.sector > nsss_pkg::SECTOR_MAX)
        begin
            w.chips   = '0;
            w.index   = '0;
            w.count   = '0;
            w.invalid = 1'b1;
            w.last    = 1'b1;
            expected_words.push_back(w);
        end
        else
        begin
            seq     = sss_chips(id.group, id.sector);
            n_words = (nsss_pkg::SEQ_LEN + nsss_pkg::CHIPS_PER_WORD - 1)
                    / nsss_pkg::CHIPS_PER_WORD;
            for (wi = 0; wi < n_words; wi++)
            begin
                w.chips   = '0;
                w.count   = '0;
                w.index   = wi[nsss_pkg::IDX_W-1:0];
                w.invalid = 1'b0;
                w.last    = (wi == n_words - 1);
                for (k = 0; k < nsss_pkg::CHIPS_PER_WORD; k++)
                begin
                    n = wi * nsss_pkg::CHIPS_PER_WORD + k;
                    if (n < nsss_pkg::SEQ_LEN)
                    begin
                        w.chips[k] = seq[n];
                        w.count    = w.count + 1'b1;
                    end
                end
                expected_words.push_back(w);
            end
        end
    endtask

    task automatic add_id(input int unsigned grp, input int unsigned sec);
        cell_id_t id;
        id.group  = grp[nsss_pkg::GROUP_W-1:0];
        id.sector = sec[nsss_pkg::SECTOR_W-1:0];
        id_queue.push_back(id);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        int i;
        add_id(0, 0);
        add_id(335, 2);
        add_id(111, 1);
        add_id(112, 0);
        add_id(223, 2);
        add_id(224, 1);
        add_id(1, 2);
        add_id(170, 1);
        add_id(336, 0);
        add_id(0, 3);
        add_id(511, 3);
        add_id(511, 0);
        add_id(256, 2);
        add_id(85, 1);
        add_id(335, 3);
        add_id(42, 0);
        for (i = 0; i < 84; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                add_id($urandom_range(0, nsss_pkg::GROUP_MAX),
                       $urandom_range(0, nsss_pkg::SECTOR_MAX));
            else
                add_id($urandom_range(0, 511), $urandom_range(0, 3));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            cell_group  <= '0;
            cell_sector <= '0;
            req_gap     = draw_gap(req_burst);
        end
        else if (!req_valid || req_ready)
        begin
            if (req_valid)
            begin
                if ($urandom_range(0, 15) == 0)
                    req_burst = !req_burst;
                req_gap = draw_gap(req_burst);
            end
            if (req_gap > 0)
            begin
                req_gap--;
                req_valid <= 1'b0;
            end
            else if (id_queue.size() > 0)
            begin
                req_valid   <= 1'b1;
                cell_group  <= id_queue[0].group;
                cell_sector <= id_queue[0].sector;
                void'(id_queue.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        sss_word_t exp_w;
        cell_id_t  id;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_gap   = draw_gap(rsp_burst);
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                id.group  = cell_group;
                id.sector = cell_sector;
                predict_sss_words(id);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: chips=%h idx=%0d cnt=%0d inv=%b last=%b",
                                 chip_word, word_index, chip_count, id_invalid, last_word);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (chip_word !== exp_w.chips || word_index !== exp_w.index ||
                        chip_count !== exp_w.count || id_invalid !== exp_w.invalid ||
                        last_word !== exp_w.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch exp: chips=%h idx=%0d cnt=%0d inv=%b last=%b",
                                     exp_w.chips, exp_w.index, exp_w.count,
                                     exp_w.invalid, exp_w.last);
                            $display("         got: chips=%h idx=%0d cnt=%0d inv=%b last=%b",
                                     chip_word, word_index, chip_count,
                                     id_invalid, last_word);
                        end
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rsp_burst = !rsp_burst;
                rsp_gap = draw_gap(rsp_burst);
            end
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        while (id_queue.size() != 0 || req_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("nr_sss_sequence_generator regression: pass");
        else
            $display("nr_sss_sequence_generator regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("nr_sss_sequence_generator regression: fail");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/nsss_pkg.sv
hw/rtl/nsss_front.sv
hw/rtl/nsss_queue.sv
hw/rtl/nsss_back.sv
hw/rtl/nr_sss_sequence_generator.sv
hw/rtl/nsss_checker.sv
test/tb_nr_sss_sequence_generator.sv
